/* rtl/core/ipip_pkg.sv */
// Shared constants, types and codes of the IPIP tunnel encapsulator.
package ipip_pkg;

  localparam int unsigned HDR_BYTES   = 34;
  localparam int unsigned ETH_BYTES   = 14;
  localparam int unsigned IP_BYTES    = 20;
  localparam int unsigned ENCAP_BYTES = HDR_BYTES + IP_BYTES;
  localparam int unsigned ADDR_W      = $clog2(ENCAP_BYTES);
  localparam int unsigned CFG_W       = 48;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_IPIP     = 8'd4;
  localparam logic [7:0]  OUTER_TTL      = 8'd64;
  localparam logic [7:0]  OUTER_VER_IHL  = 8'h45;

  // inner header byte positions
  localparam logic [ADDR_W-1:0] POS_ETYPE_HI = ADDR_W'(12);
  localparam logic [ADDR_W-1:0] POS_ETYPE_LO = ADDR_W'(13);
  localparam logic [ADDR_W-1:0] POS_TOS      = ADDR_W'(ETH_BYTES + 1);
  localparam logic [ADDR_W-1:0] POS_LEN_HI   = ADDR_W'(ETH_BYTES + 2);
  localparam logic [ADDR_W-1:0] POS_LEN_LO   = ADDR_W'(ETH_BYTES + 3);
  localparam logic [ADDR_W-1:0] POS_PROTO    = ADDR_W'(ETH_BYTES + 9);

  typedef enum logic [1:0] {
    CFG_BACKEND_MAC  = 2'd0,
    CFG_BALANCER_MAC = 2'd1,
    CFG_VIRTUAL_IP   = 2'd2,
    CFG_SERVER_IP    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DRAIN,
    ST_STREAM
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

endpackage

/* rtl/core/ipip_hdr_mem.sv */
// Header buffer: single-port-write, registered-read byte memory.
module ipip_hdr_mem (
  input  logic               clk_i,
  input  ipip_pkg::mem_wr_t  wr_i,
  input  ipip_pkg::mem_rd_t  rd_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [ipip_pkg::HDR_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ipip_hdr_gen.sv */
// Config registers, inner field capture, outer checksum and new header byte select.
module ipip_hdr_gen (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [ipip_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  ipip_pkg::mem_wr_t                 wr_i,
  input  logic [ipip_pkg::ADDR_W-1:0]       idx_i,
  output logic [7:0]                        byte_o,
  output logic                              match_o
);

  localparam logic [ipip_pkg::ADDR_W-1:0] ADDR_W_5  = ipip_pkg::ADDR_W'(5);
  localparam logic [ipip_pkg::ADDR_W-1:0] ADDR_W_11 = ipip_pkg::ADDR_W'(11);
  localparam logic [ipip_pkg::ADDR_W-1:0] ADDR_W_29 = ipip_pkg::ADDR_W'(29);
  localparam logic [ipip_pkg::ADDR_W-1:0] ADDR_W_33 = ipip_pkg::ADDR_W'(33);

  logic [47:0] backend_mac_q, balancer_mac_q;
  logic [31:0] virtual_ip_q, server_ip_q;
  logic [7:0]  etype_hi_q, etype_lo_q, tos_q, len_hi_q, len_lo_q, proto_q;
  logic [18:0] cfg_sum_q, cfg_sum_d;
  logic [15:0] cks_q, cks_d;
  logic [15:0] tot;
  logic [18:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic [ipip_pkg::ADDR_W-1:0] off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backend_mac_q  <= '0;
      balancer_mac_q <= '0;
      virtual_ip_q   <= '0;
      server_ip_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipip_pkg::CFG_BACKEND_MAC:  backend_mac_q  <= cfg_wdata_i[47:0];
        ipip_pkg::CFG_BALANCER_MAC: balancer_mac_q <= cfg_wdata_i[47:0];
        ipip_pkg::CFG_VIRTUAL_IP:   virtual_ip_q   <= cfg_wdata_i[31:0];
        ipip_pkg::CFG_SERVER_IP:    server_ip_q    <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // snoop the header fields as they are written into the buffer
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      case (wr_i.addr)
        ipip_pkg::POS_ETYPE_HI: etype_hi_q <= wr_i.data;
        ipip_pkg::POS_ETYPE_LO: etype_lo_q <= wr_i.data;
        ipip_pkg::POS_TOS:      tos_q      <= wr_i.data;
        ipip_pkg::POS_LEN_HI:   len_hi_q   <= wr_i.data;
        ipip_pkg::POS_LEN_LO:   len_lo_q   <= wr_i.data;
        ipip_pkg::POS_PROTO:    proto_q    <= wr_i.data;
        default: ;
      endcase
    end
  end

  assign match_o = ({etype_hi_q, etype_lo_q} == ipip_pkg::ETHERTYPE_IPV4) &&
                   (proto_q == ipip_pkg::PROTO_TCP);

  // constant words of the outer header plus the address words
  always_comb begin
    cfg_sum_d = 19'({ipip_pkg::OUTER_VER_IHL, 8'h00})
              + 19'({ipip_pkg::OUTER_TTL, ipip_pkg::PROTO_IPIP})
              + 19'(virtual_ip_q[31:16]) + 19'(virtual_ip_q[15:0])
              + 19'(server_ip_q[31:16])  + 19'(server_ip_q[15:0]);
  end

  always_comb begin
    tot   = {len_hi_q, len_lo_q} + 16'(ipip_pkg::IP_BYTES);
    sum   = cfg_sum_q + 19'(tos_q) + 19'(tot);
    fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
    cks_d = ~fold2;
  end

  // fields settle long before the checksum bytes are read out
  always_ff @(posedge clk_i) begin
    cfg_sum_q <= cfg_sum_d;
    cks_q     <= cks_d;
  end

  always_comb begin
    off    = '0;
    byte_o = '0;
    case (idx_i) inside
      [0:5]: begin
        off    = ADDR_W_5 - idx_i;
        byte_o = backend_mac_q[{off[2:0], 3'b000} +: 8];
      end
      [6:11]: begin
        off    = ADDR_W_11 - idx_i;
        byte_o = balancer_mac_q[{off[2:0], 3'b000} +: 8];
      end
      12: byte_o = ipip_pkg::ETHERTYPE_IPV4[15:8];
      13: byte_o = ipip_pkg::ETHERTYPE_IPV4[7:0];
      14: byte_o = ipip_pkg::OUTER_VER_IHL;
      15: byte_o = tos_q;
      16: byte_o = tot[15:8];
      17: byte_o = tot[7:0];
      22: byte_o = ipip_pkg::OUTER_TTL;
      23: byte_o = ipip_pkg::PROTO_IPIP;
      24: byte_o = cks_q[15:8];
      25: byte_o = cks_q[7:0];
      [26:29]: begin
        off    = ADDR_W_29 - idx_i;
        byte_o = virtual_ip_q[{off[1:0], 3'b000} +: 8];
      end
      [30:33]: begin
        off    = ADDR_W_33 - idx_i;
        byte_o = server_ip_q[{off[1:0], 3'b000} +: 8];
      end
      default: byte_o = '0;
    endcase
  end

endmodule

/* rtl/core/ipip_tcp_encapsulator_core.sv */
// Top level: frame sequencer, read stage and output register of the encapsulator.
// Bytes of a frame are taken one per cycle while the first 34 are written into
// the header buffer. On the 34th byte (or an earlier final byte) input stalls while
// the decided burst drains one byte per cycle, unless the output stalls, through
// the buffer's single read port: 54 bytes for an encapsulated TCP/IPv4 frame, 34
// for any other frame, the held length for a short one. The rest of the frame then
// streams through at one byte per cycle while the output is not stalled. A drained
// beat goes via the read stage, a streamed one straight into the output register.
module ipip_tcp_encapsulator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  in_byte_i,
  input  logic                        in_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_last_o,
  output logic                        verdict_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [ipip_pkg::CFG_W-1:0]  cfg_wdata_i
);

  localparam int unsigned AW = ipip_pkg::ADDR_W;
  localparam logic [AW-1:0] HDR_LAST = AW'(ipip_pkg::HDR_BYTES - 1);
  localparam logic [AW-1:0] N_HDR    = AW'(ipip_pkg::HDR_BYTES);
  localparam logic [AW-1:0] N_ENCAP  = AW'(ipip_pkg::ENCAP_BYTES);
  localparam logic [AW-1:0] N_IP     = AW'(ipip_pkg::IP_BYTES);

  ipip_pkg::state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d, d_idx_q, d_idx_d, n_q, n_d;
  logic          encap_q, encap_d, end_q, end_d;

  logic          s1_valid_q, s1_valid_d;
  logic [AW-1:0] s1_idx_q;
  logic          s1_gen_q, s1_last_q, s1_verdict_q;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d, out_verdict_q, out_verdict_d;

  logic          out_ld, in_acc, col_acc, str_acc, issue, hdr_done, drain_end;
  logic          match;
  logic [7:0]    gen_byte, rdata;
  ipip_pkg::mem_wr_t wr;
  ipip_pkg::mem_rd_t rd;

  assign out_ld    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ipip_pkg::ST_COLLECT) ||
                        ((state_q == ipip_pkg::ST_STREAM) && !s1_valid_q && out_ld));
  assign in_acc    = in_valid_i && !in_stall_o;
  assign col_acc   = in_acc && (state_q == ipip_pkg::ST_COLLECT);
  assign str_acc   = in_acc && (state_q == ipip_pkg::ST_STREAM);
  assign issue     = (state_q == ipip_pkg::ST_DRAIN) && (!s1_valid_q || out_ld);
  assign hdr_done  = in_last_i || (cnt_q == HDR_LAST);
  assign drain_end = issue && (d_idx_q == n_q - AW'(1));

  // buffer is written only while collecting and read only while draining
  assign wr.we   = col_acc;
  assign wr.addr = cnt_q;
  assign wr.data = in_byte_i;
  assign rd.re   = issue;
  assign rd.addr = (encap_q && (d_idx_q >= N_HDR)) ? d_idx_q - N_IP : d_idx_q;

  ipip_hdr_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  ipip_hdr_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_i        (wr),
    .idx_i       (s1_idx_q),
    .byte_o      (gen_byte),
    .match_o     (match)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ipip_pkg::ST_COLLECT: if (col_acc && hdr_done) state_d = ipip_pkg::ST_DRAIN;
      ipip_pkg::ST_DRAIN: begin
        if (drain_end) state_d = end_q ? ipip_pkg::ST_COLLECT : ipip_pkg::ST_STREAM;
      end
      ipip_pkg::ST_STREAM: if (str_acc && in_last_i) state_d = ipip_pkg::ST_COLLECT;
      default: state_d = ipip_pkg::ST_COLLECT;
    endcase
  end

  // sequencer counters
  always_comb begin
    cnt_d   = cnt_q;
    d_idx_d = d_idx_q;
    n_d     = n_q;
    encap_d = encap_q;
    end_d   = end_q;
    case (state_q)
      ipip_pkg::ST_COLLECT: begin
        if (col_acc) begin
          if (hdr_done) begin
            encap_d = (cnt_q == HDR_LAST) && match;
            n_d     = (cnt_q == HDR_LAST) ? (encap_d ? N_ENCAP : N_HDR) : cnt_q + AW'(1);
            end_d   = in_last_i;
            cnt_d   = '0;
            d_idx_d = '0;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
      ipip_pkg::ST_DRAIN: if (issue) d_idx_d = d_idx_q + AW'(1);
      ipip_pkg::ST_STREAM: ;
      default: cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ipip_pkg::ST_COLLECT;
      cnt_q   <= '0;
      d_idx_q <= '0;
      n_q     <= '0;
      encap_q <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      d_idx_q <= d_idx_d;
      n_q     <= n_d;
      encap_q <= encap_d;
      end_q   <= end_d;
    end
  end

  // read stage: a beat waits here while its buffer read completes or the output stalls
  assign s1_valid_d = issue || (s1_valid_q && !out_ld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q     <= d_idx_q;
      s1_gen_q     <= encap_q && (d_idx_q < N_HDR);
      s1_last_q    <= end_q && (d_idx_q == n_q - AW'(1));
      s1_verdict_q <= encap_q;
    end
  end

  // output register
  always_comb begin
    out_valid_d   = out_valid_q;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    out_verdict_d = out_verdict_q;
    if (out_ld) begin
      out_valid_d = s1_valid_q || str_acc;
      if (s1_valid_q) begin
        out_byte_d    = s1_gen_q ? gen_byte : rdata;
        out_last_d    = s1_last_q;
        out_verdict_d = s1_verdict_q;
      end else begin
        out_byte_d    = in_byte_i;
        out_last_d    = in_last_i;
        out_verdict_d = encap_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q    <= out_byte_d;
    out_last_q    <= out_last_d;
    out_verdict_q <= out_verdict_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign verdict_o   = out_verdict_q;

endmodule

/* rtl/core/ipip_chk.sv */
// Port-level checker of the encapsulator output channel, bound to the top level.
module ipip_chk (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_o,
  input  logic       out_last_o,
  input  logic       verdict_o
);

  logic       out_acc;
  logic       mid_q;
  logic       verdict_q;
  logic [6:0] beat_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // beat position within the current output frame, saturating
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q     <= 1'b0;
      verdict_q <= 1'b0;
      beat_q    <= '0;
    end else if (out_acc) begin
      mid_q     <= !out_last_o;
      verdict_q <= verdict_o;
      beat_q    <= out_last_o ? 7'd0 : ((beat_q == 7'h7f) ? beat_q : beat_q + 7'd1);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(out_last_o) && $stable(verdict_o))
    else $error("stalled output beat changed");

  a_verdict_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && mid_q |-> verdict_o == verdict_q)
    else $error("verdict changed within a frame");

  a_encap_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last_o && verdict_o |-> beat_q >= 7'd53)
    else $error("encapsulated frame shorter than its headers");

  a_outer_ver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && verdict_o && beat_q == 7'd14 |-> out_byte_o == 8'h45)
    else $error("outer header does not open with version and length");

  a_outer_proto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && verdict_o && beat_q == 7'd23 |-> out_byte_o == 8'd4)
    else $error("outer header protocol is not IPIP");

endmodule

bind ipip_tcp_encapsulator_core ipip_chk u_ipip_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o),
  .verdict_o   (verdict_o)
);
